@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the mode controller RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define WFMC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define WFMC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WFMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/wfmc_pkg.sv @@
// Shared types, constants and helper functions of the wall-follow mode controller.
// No dependencies; used by every RTL file of the block.
`default_nettype none

package wfmc_pkg;

  // Distance limits and front filter constants.
  localparam logic [8:0] MaxCm    = 9'd400;
  localparam logic [3:0] FarTolCm = 4'd15;
  localparam logic [2:0] FarHold  = 3'd4;

  // Configuration port geometry.
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  // Register reset values.
  localparam logic [8:0] FrontBlockedRst  = 9'd45;
  localparam logic [8:0] FrontSlowdownRst = 9'd75;
  localparam logic [8:0] SideOpenRst      = 9'd40;
  localparam logic [7:0] OpenConfirmRst   = 8'd2;
  localparam logic [7:0] BrakeSettleRst   = 8'd6;
  localparam logic [7:0] GuardRst         = 8'd40;
  localparam logic [7:0] CorridorRst      = 8'd4;
  localparam logic [7:0] LostTimeoutRst   = 8'd100;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_FOLLOW = 3'd1,
    MODE_LOST   = 3'd2,
    MODE_STOP   = 3'd3,
    MODE_LEFT   = 3'd4,
    MODE_RIGHT  = 3'd5,
    MODE_POST   = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    DRV_NONE   = 3'd0,
    DRV_CRUISE = 3'd1,
    DRV_SLOW   = 3'd2,
    DRV_SPIN_L = 3'd3,
    DRV_SPIN_R = 3'd4,
    DRV_STOP   = 3'd5,
    DRV_BRAKE  = 3'd6
  } drive_e;

  typedef enum logic [2:0] {
    REG_FRONT_BLOCKED  = 3'd0,
    REG_FRONT_SLOWDOWN = 3'd1,
    REG_SIDE_OPEN      = 3'd2,
    REG_OPEN_CONFIRM   = 3'd3,
    REG_BRAKE_SETTLE   = 3'd4,
    REG_GUARD          = 3'd5,
    REG_CORRIDOR       = 3'd6,
    REG_LOST_TIMEOUT   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [8:0] front_exit_cm;
    logic [8:0] front_slow_cm;
    logic [8:0] side_open_cm;
    logic [7:0] open_confirm_ticks;
    logic [7:0] brake_settle_ticks;
    logic [7:0] guard_ticks;
    logic [7:0] corridor_confirm_ticks;
    logic [7:0] lost_limit_ticks;
  } cfg_t;

  typedef struct packed {
    logic [8:0] front_cm;
    logic [8:0] left_cm;
    logic [8:0] right_cm;
    logic       calib_finished;
    logic       start_seen;
    logic       rotation_finished;
  } in_t;

  typedef struct packed {
    mode_e       mode;
    logic        mode_changed;
    drive_e      drive_cmd;
    logic        pid_clear;
    logic        pid_step;
    logic        calib_request;
    logic        rotation_poll;
    logic [15:0] turns_done;
    logic [8:0]  front_filtered_cm;
  } out_t;

  // Clamp a raw distance to the sensor range.
  function automatic logic [8:0] sat_cm(input logic [8:0] v);
    return (v > MaxCm) ? MaxCm : v;
  endfunction

  // Eight-bit counter increment that sticks at its maximum.
  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wfmc_cfg_regs.sv @@
// Configuration register file with an APB-style slave port.
// Depends on wfmc_pkg for the register layout and reset values.
`default_nettype none

module wfmc_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wfmc_pkg::ApbAddrW-1:0]     paddr,
  input  logic [wfmc_pkg::ApbDataW-1:0]     pwdata,
  output logic [wfmc_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready,
  output wfmc_pkg::cfg_t                    cfg_o
);

  wfmc_pkg::cfg_t     cfg_q, cfg_d;
  wfmc_pkg::reg_idx_e idx;
  logic               wr_en;

  // Word index from the byte address; the access phase commits a write.
  assign idx    = wfmc_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        wfmc_pkg::REG_FRONT_BLOCKED:  cfg_d.front_exit_cm          = pwdata[8:0];
        wfmc_pkg::REG_FRONT_SLOWDOWN: cfg_d.front_slow_cm          = pwdata[8:0];
        wfmc_pkg::REG_SIDE_OPEN:      cfg_d.side_open_cm           = pwdata[8:0];
        wfmc_pkg::REG_OPEN_CONFIRM:   cfg_d.open_confirm_ticks     = pwdata[7:0];
        wfmc_pkg::REG_BRAKE_SETTLE:   cfg_d.brake_settle_ticks     = pwdata[7:0];
        wfmc_pkg::REG_GUARD:          cfg_d.guard_ticks            = pwdata[7:0];
        wfmc_pkg::REG_CORRIDOR:       cfg_d.corridor_confirm_ticks = pwdata[7:0];
        wfmc_pkg::REG_LOST_TIMEOUT:   cfg_d.lost_limit_ticks       = pwdata[7:0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  // Read decode.
  always_comb begin
    unique case (idx)
      wfmc_pkg::REG_FRONT_BLOCKED:  prdata = 32'(cfg_q.front_exit_cm);
      wfmc_pkg::REG_FRONT_SLOWDOWN: prdata = 32'(cfg_q.front_slow_cm);
      wfmc_pkg::REG_SIDE_OPEN:      prdata = 32'(cfg_q.side_open_cm);
      wfmc_pkg::REG_OPEN_CONFIRM:   prdata = 32'(cfg_q.open_confirm_ticks);
      wfmc_pkg::REG_BRAKE_SETTLE:   prdata = 32'(cfg_q.brake_settle_ticks);
      wfmc_pkg::REG_GUARD:          prdata = 32'(cfg_q.guard_ticks);
      wfmc_pkg::REG_CORRIDOR:       prdata = 32'(cfg_q.corridor_confirm_ticks);
      wfmc_pkg::REG_LOST_TIMEOUT:   prdata = 32'(cfg_q.lost_limit_ticks);
      default:                      prdata = '0;
    endcase
  end

  // Register storage with documented reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.front_exit_cm          <= wfmc_pkg::FrontBlockedRst;
      cfg_q.front_slow_cm          <= wfmc_pkg::FrontSlowdownRst;
      cfg_q.side_open_cm           <= wfmc_pkg::SideOpenRst;
      cfg_q.open_confirm_ticks     <= wfmc_pkg::OpenConfirmRst;
      cfg_q.brake_settle_ticks     <= wfmc_pkg::BrakeSettleRst;
      cfg_q.guard_ticks            <= wfmc_pkg::GuardRst;
      cfg_q.corridor_confirm_ticks <= wfmc_pkg::CorridorRst;
      cfg_q.lost_limit_ticks       <= wfmc_pkg::LostTimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/wfmc_core.sv @@
// Mode state machine, counters and front filter; one tick per step strobe.
// Depends on wfmc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module wfmc_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  wfmc_pkg::in_t  item_i,
  input  wfmc_pkg::cfg_t cfg_i,
  output wfmc_pkg::out_t res_o
);

  // State registers.
  wfmc_pkg::mode_e mode_q, mode_d;
  logic [15:0]     turn_total_q, turn_total_d;
  logic [7:0]      lost_q, lost_d;
  logic            spin_q, spin_d;
  logic [7:0]      settle_q, settle_d;
  logic [7:0]      guard_q, guard_d;
  logic [7:0]      corr_q, corr_d;
  logic [7:0]      left_open_q, left_open_d;
  logic [7:0]      right_open_q, right_open_d;
  logic [8:0]      held_q, held_d;
  logic [2:0]      far_q, far_d;
  logic            calib_q, calib_d;
  logic            start_q, start_d;

  // Saturated distances and side tests.
  logic [8:0] fr_cm, l_cm, r_cm;
  logic       l_open, r_open, any_near, both_near;
  assign fr_cm     = wfmc_pkg::sat_cm(item_i.front_cm);
  assign l_cm      = wfmc_pkg::sat_cm(item_i.left_cm);
  assign r_cm      = wfmc_pkg::sat_cm(item_i.right_cm);
  assign l_open    = l_cm >= cfg_i.side_open_cm;
  assign r_open    = r_cm >= cfg_i.side_open_cm;
  assign any_near  = (fr_cm < cfg_i.side_open_cm) || !l_open || !r_open;
  assign both_near = !l_open && !r_open;

  // Asymmetric front filter: near readings pass, far ones need a run of FarHold.
  logic       near_ok;
  logic [2:0] far_inc;
  logic [8:0] filt_held;
  logic [2:0] filt_far;
  assign near_ok = 10'(fr_cm) <= (10'(held_q) + 10'(wfmc_pkg::FarTolCm));
  assign far_inc = far_q + 3'd1;
  always_comb begin
    if (near_ok || (far_inc >= wfmc_pkg::FarHold)) begin
      filt_held = fr_cm;
      filt_far  = '0;
    end else begin
      filt_held = held_q;
      filt_far  = far_inc;
    end
  end

  // Counter candidates for this tick.
  logic [7:0] lcnt, rcnt, lost_inc, settle_inc, guard_inc, corr_inc;
  logic       slow, lo, ro, guard_wait, post_blocked, corr_exit, start_now;
  assign lcnt         = l_open ? wfmc_pkg::sat_inc(left_open_q) : '0;
  assign rcnt         = r_open ? wfmc_pkg::sat_inc(right_open_q) : '0;
  assign lost_inc     = wfmc_pkg::sat_inc(lost_q);
  assign settle_inc   = wfmc_pkg::sat_inc(settle_q);
  assign guard_inc    = wfmc_pkg::sat_inc(guard_q);
  assign corr_inc     = wfmc_pkg::sat_inc(corr_q);
  assign slow         = filt_held <= cfg_i.front_slow_cm;
  assign lo           = lcnt >= cfg_i.open_confirm_ticks;
  assign ro           = rcnt >= cfg_i.open_confirm_ticks;
  assign guard_wait   = guard_inc < cfg_i.guard_ticks;
  assign post_blocked = filt_held <= cfg_i.front_exit_cm;
  assign corr_exit    = both_near && (corr_inc >= cfg_i.corridor_confirm_ticks);
  assign start_now    = start_q || item_i.start_seen;

  // Next mode.
  always_comb begin
    mode_d = mode_q;
    if (step_i) begin
      unique case (mode_q) inside
        wfmc_pkg::MODE_FOLLOW: begin
          if (slow && lo && ro) begin
            mode_d = (l_cm > r_cm) ? wfmc_pkg::MODE_LEFT : wfmc_pkg::MODE_RIGHT;
          end else if (slow && lo) begin
            mode_d = wfmc_pkg::MODE_LEFT;
          end else if (slow && ro) begin
            mode_d = wfmc_pkg::MODE_RIGHT;
          end
        end
        wfmc_pkg::MODE_LOST: begin
          if (lost_inc >= cfg_i.lost_limit_ticks) begin
            mode_d = wfmc_pkg::MODE_STOP;
          end else if (any_near) begin
            mode_d = wfmc_pkg::MODE_FOLLOW;
          end
        end
        wfmc_pkg::MODE_STOP: begin
          mode_d = wfmc_pkg::MODE_FOLLOW;
        end
        wfmc_pkg::MODE_LEFT, wfmc_pkg::MODE_RIGHT: begin
          if (spin_q && item_i.rotation_finished) begin
            mode_d = wfmc_pkg::MODE_POST;
          end
        end
        wfmc_pkg::MODE_POST: begin
          if (!guard_wait && (post_blocked || corr_exit)) begin
            mode_d = wfmc_pkg::MODE_FOLLOW;
          end
        end
        default: begin
          if (calib_q && start_now) begin
            mode_d = wfmc_pkg::MODE_FOLLOW;
          end
        end
      endcase
    end
  end

  logic        mode_changed;
  logic        turn_entry;
  logic [15:0] turn_next;
  assign mode_changed = step_i && (mode_d != mode_q);
  assign turn_entry   = mode_changed &&
                        (mode_d == wfmc_pkg::MODE_LEFT || mode_d == wfmc_pkg::MODE_RIGHT);
  assign turn_next    = turn_total_q + 16'd1;

  // Per-mode work, entry actions and the result item.
  always_comb begin
    turn_total_d = turn_total_q;
    lost_d       = lost_q;
    spin_d       = spin_q;
    settle_d     = settle_q;
    guard_d      = guard_q;
    corr_d       = corr_q;
    left_open_d  = left_open_q;
    right_open_d = right_open_q;
    held_d       = held_q;
    far_d        = far_q;
    calib_d      = calib_q;
    start_d      = start_q;
    res_o        = '0;
    res_o.drive_cmd = wfmc_pkg::DRV_NONE;

    if (step_i) begin
      start_d = start_now;
      unique case (mode_q) inside
        wfmc_pkg::MODE_FOLLOW: begin
          held_d = filt_held;
          far_d  = filt_far;
          if (slow) begin
            left_open_d  = lcnt;
            right_open_d = rcnt;
            if (!lo && !ro) begin
              res_o.drive_cmd = wfmc_pkg::DRV_SLOW;
            end
          end else begin
            left_open_d     = '0;
            right_open_d    = '0;
            res_o.drive_cmd = wfmc_pkg::DRV_CRUISE;
          end
        end
        wfmc_pkg::MODE_LOST: begin
          lost_d = lost_inc;
        end
        wfmc_pkg::MODE_STOP: begin
          lost_d = lost_q;
        end
        wfmc_pkg::MODE_LEFT, wfmc_pkg::MODE_RIGHT: begin
          if (!spin_q) begin
            settle_d = settle_inc;
            if (settle_inc >= cfg_i.brake_settle_ticks) begin
              spin_d          = 1'b1;
              res_o.drive_cmd = (mode_q == wfmc_pkg::MODE_LEFT) ?
                                wfmc_pkg::DRV_SPIN_L : wfmc_pkg::DRV_SPIN_R;
            end
          end else begin
            res_o.rotation_poll = 1'b1;
          end
        end
        wfmc_pkg::MODE_POST: begin
          guard_d = guard_inc;
          held_d  = filt_held;
          far_d   = filt_far;
          if (guard_wait) begin
            corr_d         = '0;
            res_o.pid_step = 1'b1;
          end else if (post_blocked) begin
            guard_d = '0;
            corr_d  = '0;
          end else if (corr_exit) begin
            guard_d = '0;
            corr_d  = '0;
          end else begin
            corr_d         = both_near ? corr_inc : '0;
            res_o.pid_step = 1'b1;
          end
        end
        default: begin
          if (!calib_q) begin
            res_o.calib_request = 1'b1;
            calib_d             = item_i.calib_finished;
          end
        end
      endcase

      // Entry actions of the new mode.
      if (mode_changed) begin
        unique case (mode_d) inside
          wfmc_pkg::MODE_FOLLOW: begin
            res_o.pid_clear = 1'b1;
            left_open_d     = '0;
            right_open_d    = '0;
          end
          wfmc_pkg::MODE_LOST: begin
            res_o.drive_cmd = wfmc_pkg::DRV_STOP;
            lost_d          = '0;
          end
          wfmc_pkg::MODE_STOP: begin
            res_o.drive_cmd = wfmc_pkg::DRV_STOP;
          end
          wfmc_pkg::MODE_LEFT, wfmc_pkg::MODE_RIGHT: begin
            res_o.drive_cmd = wfmc_pkg::DRV_BRAKE;
            spin_d          = 1'b0;
            settle_d        = '0;
            turn_total_d    = turn_next;
          end
          wfmc_pkg::MODE_POST: begin
            guard_d         = '0;
            corr_d          = '0;
            res_o.pid_clear = 1'b1;
            res_o.drive_cmd = wfmc_pkg::DRV_CRUISE;
          end
          default: begin
            res_o.pid_clear = 1'b0;
          end
        endcase
      end
    end

    res_o.mode              = mode_d;
    res_o.mode_changed      = mode_changed;
    res_o.turns_done        = turn_total_d;
    res_o.front_filtered_cm = held_d;
  end

  // State update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= wfmc_pkg::MODE_IDLE;
      turn_total_q <= '0;
      lost_q       <= '0;
      spin_q       <= 1'b0;
      settle_q     <= '0;
      guard_q      <= '0;
      corr_q       <= '0;
      left_open_q  <= '0;
      right_open_q <= '0;
      held_q       <= wfmc_pkg::MaxCm;
      far_q        <= '0;
      calib_q      <= 1'b0;
      start_q      <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      turn_total_q <= turn_total_d;
      lost_q       <= lost_d;
      spin_q       <= spin_d;
      settle_q     <= settle_d;
      guard_q      <= guard_d;
      corr_q       <= corr_d;
      left_open_q  <= left_open_d;
      right_open_q <= right_open_d;
      held_q       <= held_d;
      far_q        <= far_d;
      calib_q      <= calib_d;
      start_q      <= start_d;
    end
  end

  // The far-reading run never reaches the hold length in storage.
  `WFMC_ASSERT(a_far_run_short, clk_i, rst_ni, far_q < wfmc_pkg::FarHold, "far run overflow")
  // Entering a turn bumps the turn count by exactly one.
  `WFMC_ASSERT_NEXT(a_turn_cnt, clk_i, rst_ni, turn_entry, turn_total_q == $past(turn_next), "turn count")
  // A lane controller step never coincides with a mode change.
  `WFMC_ASSERT_IMPL(a_step_no_change, clk_i, rst_ni, res_o.pid_step, !mode_changed, "step on change")

endmodule

`default_nettype wire

@@ hw/rtl/wall_follow_mode_controller.sv @@
// Top level of the wall-follow mode controller: input register, core, result register.
// Depends on wfmc_pkg, wfmc_cfg_regs and wfmc_core.
//
//   Channel  Signals                                  Beat
//   in       in_valid_i / in_ready_o / in_i           one tick of sensor data
//   out      out_valid_o / out_ready_i / out_o        one result per tick
//   cfg      psel penable pwrite paddr pwdata prdata  one register access
//
// One tick is accepted per cycle unless the result register stalls.
// The single state update in the core sets the rate, one tick a cycle unless stalled.
// Reset sets state, config registers and valid flags at once; payloads are not reset.
// A stalled result holds the core; the input register still takes one beat.
`default_nettype none

module wall_follow_mode_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  wfmc_pkg::in_t                 in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wfmc_pkg::out_t                out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wfmc_pkg::ApbAddrW-1:0] paddr,
  input  logic [wfmc_pkg::ApbDataW-1:0] pwdata,
  output logic [wfmc_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  wfmc_pkg::cfg_t cfg;
  wfmc_pkg::in_t  in_q;
  wfmc_pkg::out_t out_q, res;
  logic           in_valid_q, out_valid_q, advance;

  // The core runs a tick when the result register is free or draining.
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  wfmc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wfmc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Valid flags of the input and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

@@ sim/wfmc_checker.sv @@
// Checker for the wall-follow mode controller: predicts each result and compares it.
// Depends on wfmc_pkg; instantiated beside the block by tb_wall_follow_mode_controller.

module wfmc_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  wfmc_pkg::in_t                 in_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  wfmc_pkg::out_t                out_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [wfmc_pkg::ApbAddrW-1:0] paddr_i,
  input  logic [wfmc_pkg::ApbDataW-1:0] pwdata_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  import wfmc_pkg::*;

  // Shadow copy of the registers and of the navigation state.
  cfg_t        cfg;
  mode_e       nav_mode;
  logic [15:0] turn_cnt;
  logic [7:0]  lost_cnt;
  logic [7:0]  settle_cnt;
  logic [7:0]  guard_cnt;
  logic [7:0]  corridor_cnt;
  logic [7:0]  left_open_cnt;
  logic [7:0]  right_open_cnt;
  logic        spin_on;
  logic        calibrated;
  logic        start_held;
  logic [8:0]  front_hold;
  logic [2:0]  far_cnt;

  // Predicted command sets, oldest first.
  out_t        predicted_cmds[$];
  int unsigned mismatches;

  // Distances beyond the sensor range read as the range limit.
  function automatic logic [8:0] clamp_cm(input logic [8:0] v);
    return (v > MaxCm) ? MaxCm : v;
  endfunction

  // Tick counters stop at their top value.
  function automatic logic [7:0] bump(input logic [7:0] v);
    return (v < 8'd255) ? v + 8'd1 : v;
  endfunction

  // Close readings pass at once; a far jump must persist before it is believed.
  function automatic logic [8:0] track_front(input logic [8:0] raw);
    if (int'(raw) <= int'(front_hold) + int'(FarTolCm)) begin
      front_hold = raw;
      far_cnt    = '0;
    end else begin
      far_cnt = far_cnt + 3'd1;
      if (far_cnt >= FarHold) begin
        front_hold = raw;
        far_cnt    = '0;
      end
    end
    return front_hold;
  endfunction

  // Advance the shadow state by one tick and form the commands it produces.
  task automatic next_commands(input in_t t, output out_t r);
    logic [8:0] fr;
    logic [8:0] lc;
    logic [8:0] rc;
    logic [8:0] f;
    mode_e      nxt;
    drive_e     drv;
    logic       clr;
    logic       stp;
    logic       creq;
    logic       poll;
    logic       chg;
    logic       lo;
    logic       ro;
    logic       exit_now;
    fr   = clamp_cm(t.front_cm);
    lc   = clamp_cm(t.left_cm);
    rc   = clamp_cm(t.right_cm);
    nxt  = nav_mode;
    drv  = DRV_NONE;
    clr  = 1'b0;
    stp  = 1'b0;
    creq = 1'b0;
    poll = 1'b0;
    chg  = 1'b0;
    if (t.start_seen) start_held = 1'b1;

    case (nav_mode)
      MODE_FOLLOW: begin
        f = track_front(fr);
        if (f <= cfg.front_slow_cm) begin
          left_open_cnt  = (lc >= cfg.side_open_cm) ? bump(left_open_cnt) : 8'd0;
          right_open_cnt = (rc >= cfg.side_open_cm) ? bump(right_open_cnt) : 8'd0;
          lo = left_open_cnt >= cfg.open_confirm_ticks;
          ro = right_open_cnt >= cfg.open_confirm_ticks;
          if (lo && ro) nxt = (lc > rc) ? MODE_LEFT : MODE_RIGHT;
          else if (lo) nxt = MODE_LEFT;
          else if (ro) nxt = MODE_RIGHT;
          else drv = DRV_SLOW;
        end else begin
          left_open_cnt  = 8'd0;
          right_open_cnt = 8'd0;
          drv            = DRV_CRUISE;
        end
      end
      MODE_LOST: begin
        lost_cnt = bump(lost_cnt);
        if (lost_cnt >= cfg.lost_limit_ticks) begin
          nxt = MODE_STOP;
        end else if (fr < cfg.side_open_cm || lc < cfg.side_open_cm ||
                     rc < cfg.side_open_cm) begin
          nxt = MODE_FOLLOW;
        end
      end
      MODE_STOP: nxt = MODE_FOLLOW;
      MODE_LEFT, MODE_RIGHT: begin
        if (!spin_on) begin
          settle_cnt = bump(settle_cnt);
          if (settle_cnt >= cfg.brake_settle_ticks) begin
            drv     = (nav_mode == MODE_LEFT) ? DRV_SPIN_L : DRV_SPIN_R;
            spin_on = 1'b1;
          end
        end else begin
          poll = 1'b1;
          if (t.rotation_finished) nxt = MODE_POST;
        end
      end
      MODE_POST: begin
        guard_cnt = bump(guard_cnt);
        f = track_front(fr);
        if (guard_cnt < cfg.guard_ticks) begin
          corridor_cnt = 8'd0;
          stp          = 1'b1;
        end else if (f <= cfg.front_exit_cm) begin
          guard_cnt    = 8'd0;
          corridor_cnt = 8'd0;
          nxt          = MODE_FOLLOW;
        end else begin
          exit_now = 1'b0;
          if (lc < cfg.side_open_cm && rc < cfg.side_open_cm) begin
            corridor_cnt = bump(corridor_cnt);
            if (corridor_cnt >= cfg.corridor_confirm_ticks) begin
              guard_cnt    = 8'd0;
              corridor_cnt = 8'd0;
              nxt          = MODE_FOLLOW;
              exit_now     = 1'b1;
            end
          end else begin
            corridor_cnt = 8'd0;
          end
          if (!exit_now) stp = 1'b1;
        end
      end
      default: begin
        if (!calibrated) begin
          creq = 1'b1;
          if (t.calib_finished) calibrated = 1'b1;
        end else if (start_held) begin
          nxt = MODE_FOLLOW;
        end
      end
    endcase

    // Actions taken on entry to the new mode.
    if (nxt != nav_mode) begin
      chg = 1'b1;
      case (nxt)
        MODE_FOLLOW: begin
          clr            = 1'b1;
          left_open_cnt  = 8'd0;
          right_open_cnt = 8'd0;
        end
        MODE_LOST: begin
          drv      = DRV_STOP;
          lost_cnt = 8'd0;
        end
        MODE_STOP: drv = DRV_STOP;
        MODE_LEFT, MODE_RIGHT: begin
          drv        = DRV_BRAKE;
          spin_on    = 1'b0;
          settle_cnt = 8'd0;
          turn_cnt   = turn_cnt + 16'd1;
        end
        MODE_POST: begin
          guard_cnt    = 8'd0;
          corridor_cnt = 8'd0;
          clr          = 1'b1;
          drv          = DRV_CRUISE;
        end
        default: ;
      endcase
      nav_mode = nxt;
    end

    r.mode              = nav_mode;
    r.mode_changed      = chg;
    r.drive_cmd         = drv;
    r.pid_clear         = clr;
    r.pid_step          = stp;
    r.calib_request     = creq;
    r.rotation_poll     = poll;
    r.turns_done        = turn_cnt;
    r.front_filtered_cm = front_hold;
  endtask

  // Report one field that differs from its prediction.
  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Follow register writes, predict every tick beat and compare every result beat.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    out_t got;
    if (!rst_ni) begin
      cfg.front_exit_cm          = FrontBlockedRst;
      cfg.front_slow_cm          = FrontSlowdownRst;
      cfg.side_open_cm           = SideOpenRst;
      cfg.open_confirm_ticks     = OpenConfirmRst;
      cfg.brake_settle_ticks     = BrakeSettleRst;
      cfg.guard_ticks            = GuardRst;
      cfg.corridor_confirm_ticks = CorridorRst;
      cfg.lost_limit_ticks       = LostTimeoutRst;
      nav_mode       = MODE_IDLE;
      turn_cnt       = '0;
      lost_cnt       = '0;
      settle_cnt     = '0;
      guard_cnt      = '0;
      corridor_cnt   = '0;
      left_open_cnt  = '0;
      right_open_cnt = '0;
      spin_on        = 1'b0;
      calibrated     = 1'b0;
      start_held     = 1'b0;
      front_hold     = MaxCm;
      far_cnt        = '0;
      predicted_cmds.delete();
      mismatches     = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[ApbAddrW-1:2]))
          REG_FRONT_BLOCKED:  cfg.front_exit_cm          = pwdata_i[8:0];
          REG_FRONT_SLOWDOWN: cfg.front_slow_cm          = pwdata_i[8:0];
          REG_SIDE_OPEN:      cfg.side_open_cm           = pwdata_i[8:0];
          REG_OPEN_CONFIRM:   cfg.open_confirm_ticks     = pwdata_i[7:0];
          REG_BRAKE_SETTLE:   cfg.brake_settle_ticks     = pwdata_i[7:0];
          REG_GUARD:          cfg.guard_ticks            = pwdata_i[7:0];
          REG_CORRIDOR:       cfg.corridor_confirm_ticks = pwdata_i[7:0];
          REG_LOST_TIMEOUT:   cfg.lost_limit_ticks       = pwdata_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        next_commands(in_i, want);
        predicted_cmds.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        got = out_i;
        if (predicted_cmds.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with no tick pending, expected none, actual %p",
                   $time, got);
        end else begin
          want = predicted_cmds.pop_front();
          check_field("mode", want.mode, got.mode);
          check_field("mode_changed", want.mode_changed, got.mode_changed);
          check_field("drive_cmd", want.drive_cmd, got.drive_cmd);
          check_field("pid_clear", want.pid_clear, got.pid_clear);
          check_field("pid_step", want.pid_step, got.pid_step);
          check_field("calib_request", want.calib_request, got.calib_request);
          check_field("rotation_poll", want.rotation_poll, got.rotation_poll);
          check_field("turns_done", want.turns_done, got.turns_done);
          check_field("front_filtered_cm", want.front_filtered_cm, got.front_filtered_cm);
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= predicted_cmds.size();
  end

endmodule

@@ sim/tb_wall_follow_mode_controller.sv @@
// Testbench top for the wall-follow mode controller: clock, reset, tick and register stimulus.
// Depends on wfmc_pkg, wall_follow_mode_controller and wfmc_checker; gives the verdict.

module tb_wall_follow_mode_controller;
  import wfmc_pkg::*;

  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned TicksPerPhase = 216;
  localparam int unsigned StallLimit   = 3000;
  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned SettleCycles = 20;

  typedef enum int unsigned {
    SEG_CRUISE,
    SEG_APPROACH,
    SEG_CORNER,
    SEG_CORRIDOR,
    SEG_NOISE
  } seg_e;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_t                 in_beat   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_beat;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ApbAddrW-1:0] paddr     = '0;
  logic [ApbDataW-1:0] pwdata    = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         quiet_cycles = 0;
  logic                tx_idle_on = 1'b1;
  logic                rx_idle_on = 1'b1;
  logic                rx_hold    = 1'b0;

  // Register values as last written, used to aim distances at the thresholds.
  cfg_t cfg_now = '{FrontBlockedRst, FrontSlowdownRst, SideOpenRst, OpenConfirmRst,
                    BrakeSettleRst, GuardRst, CorridorRst, LostTimeoutRst};

  always #5 clk_i = ~clk_i;

  wall_follow_mode_controller u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_beat),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  wfmc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_i         (in_beat),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_i        (out_beat),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Distance strictly under a threshold, or zero when none exists.
  function automatic logic [8:0] below(input logic [8:0] thr);
    return (thr == 9'd0) ? 9'd0 : 9'($urandom_range(0, thr - 1));
  endfunction

  // Distance at or over a threshold, up to the full field width.
  function automatic logic [8:0] at_or_over(input logic [8:0] thr);
    return 9'($urandom_range(thr, 511));
  endfunction

  // Distance strictly over a threshold where the field allows it.
  function automatic logic [8:0] over(input logic [8:0] thr);
    return (thr >= 9'd511) ? 9'd511 : 9'($urandom_range(thr + 1, 511));
  endfunction

  function automatic in_t sensors(input int unsigned fr, input int unsigned l,
                                  input int unsigned r, input bit cal, input bit st,
                                  input bit rot);
    in_t t;
    t.front_cm          = 9'(fr);
    t.left_cm           = 9'(l);
    t.right_cm          = 9'(r);
    t.calib_finished    = cal;
    t.start_seen        = st;
    t.rotation_finished = rot;
    return t;
  endfunction

  // One random tick shaped by the kind of stretch the robot is driving through.
  function automatic in_t make_tick(input seg_e kind);
    in_t        t;
    logic [8:0] so;
    so = cfg_now.side_open_cm;
    t.calib_finished    = 1'($urandom_range(0, 1));
    t.start_seen        = ($urandom_range(0, 7) == 0);
    t.rotation_finished = ($urandom_range(0, 3) == 0);
    t.left_cm           = below(so);
    t.right_cm          = below(so);
    case (kind)
      SEG_CRUISE:   t.front_cm = over(cfg_now.front_slow_cm);
      SEG_APPROACH: t.front_cm = 9'($urandom_range(0, cfg_now.front_slow_cm));
      SEG_CORNER: begin
        t.front_cm = 9'($urandom_range(0, cfg_now.front_slow_cm));
        if ($urandom_range(0, 9) < 6) t.left_cm = at_or_over(so);
        if ($urandom_range(0, 9) < 6) t.right_cm = at_or_over(so);
      end
      SEG_CORRIDOR: t.front_cm = over(cfg_now.front_exit_cm);
      default: begin
        t.front_cm = 9'($urandom_range(0, 511));
        t.left_cm  = 9'($urandom_range(0, 511));
        t.right_cm = 9'($urandom_range(0, 511));
      end
    endcase
    return t;
  endfunction

  // Offer one tick beat after a random gap and hold it until it is taken.
  task automatic send_tick(input in_t t);
    int unsigned gap;
    @(negedge clk_i);
    gap = (rx_hold || !tx_idle_on) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= t;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Stop offering and wait until every predicted result has been seen.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Setup and access phase of one register write; the caller closes the transfer.
  task automatic cfg_write(input reg_idx_e idx, input logic [ApbDataW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic apply_settings(input logic [8:0] fb, input logic [8:0] fs,
                                input logic [8:0] so, input logic [7:0] oc,
                                input logic [7:0] bs, input logic [7:0] gd,
                                input logic [7:0] cc, input logic [7:0] lt);
    cfg_write(REG_FRONT_BLOCKED, ApbDataW'(fb));
    cfg_write(REG_FRONT_SLOWDOWN, ApbDataW'(fs));
    cfg_write(REG_SIDE_OPEN, ApbDataW'(so));
    cfg_write(REG_OPEN_CONFIRM, ApbDataW'(oc));
    cfg_write(REG_BRAKE_SETTLE, ApbDataW'(bs));
    cfg_write(REG_GUARD, ApbDataW'(gd));
    cfg_write(REG_CORRIDOR, ApbDataW'(cc));
    cfg_write(REG_LOST_TIMEOUT, ApbDataW'(lt));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_now = '{fb, fs, so, oc, bs, gd, cc, lt};
  endtask

  // Result side: random stalls, quiet stretches, and two long hold-offs that back up the block.
  initial begin : result_sink
    int unsigned stall;
    int unsigned beats;
    beats = 0;
    forever begin
      @(negedge clk_i);
      if (beats % 40 == 0) rx_idle_on = ($urandom_range(0, 2) != 0);
      if (beats == 150 || beats == 1100) begin
        rx_hold = 1'b1;
        stall   = HoldCycles;
      end else begin
        stall = rx_idle_on ? $urandom_range(0, 14) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rx_hold = 1'b0;
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      beats++;
    end
  end

  // Watchdog on cycles in which no beat and no register access completes.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reset, a directed run through one full turn, then random phases under several settings.
  initial begin : stimulus
    seg_e        kind;
    int unsigned seg_left;
    int unsigned pick;
    kind     = SEG_CRUISE;
    seg_left = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Idle: calibration request, start latched before calibration, then calibration done.
    send_tick(sensors(400, 0, 0, 0, 0, 0));
    send_tick(sensors(400, 0, 0, 0, 1, 0));
    send_tick(sensors(400, 0, 0, 1, 0, 0));
    send_tick(sensors(400, 0, 0, 0, 0, 0));
    // Follow: saturated reading, slowdown, a far jump that must persist four ticks.
    send_tick(sensors(511, 10, 10, 0, 0, 0));
    send_tick(sensors(60, 10, 10, 0, 0, 0));
    send_tick(sensors(100, 10, 10, 0, 0, 0));
    send_tick(sensors(100, 10, 10, 0, 0, 0));
    send_tick(sensors(100, 10, 10, 0, 0, 0));
    send_tick(sensors(100, 10, 10, 0, 0, 0));
    // Left side opens for two ticks, then brake, settle and spin.
    send_tick(sensors(0, 511, 30, 0, 0, 0));
    send_tick(sensors(0, 511, 30, 0, 0, 0));
    for (int i = 0; i < 6; i++) send_tick(sensors(0, 30, 30, 0, 0, 0));
    // Rotation polled until finished, then the post-turn guard.
    send_tick(sensors(0, 30, 30, 0, 0, 0));
    send_tick(sensors(0, 30, 30, 0, 0, 1));
    for (int i = 0; i < 3; i++) send_tick(sensors(400, 10, 10, 1, 1, 1));

    for (int ph = 0; ph < PhaseCount; ph++) begin
      if (ph > 0) begin
        drain_results();
        case (ph)
          1: apply_settings(9'd0, 9'd0, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
          2: apply_settings(MaxCm, MaxCm, MaxCm, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
          3: apply_settings(9'd0, MaxCm, MaxCm, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
          default: begin
            apply_settings(9'($urandom_range(0, 200)), 9'($urandom_range(30, 300)),
                           9'($urandom_range(1, 200)), 8'($urandom_range(1, 6)),
                           8'($urandom_range(1, 12)), 8'($urandom_range(1, 30)),
                           8'($urandom_range(1, 8)), 8'($urandom_range(1, 255)));
          end
        endcase
      end
      seg_left = 0;
      for (int n = 0; n < TicksPerPhase; n++) begin
        if (seg_left == 0) begin
          pick = $urandom_range(0, 9);
          if (pick < 2) kind = SEG_CRUISE;
          else if (pick < 4) kind = SEG_APPROACH;
          else if (pick < 7) kind = SEG_CORNER;
          else if (pick < 9) kind = SEG_CORRIDOR;
          else kind = SEG_NOISE;
          seg_left   = $urandom_range(1, 40);
          tx_idle_on = ($urandom_range(0, 2) != 0);
        end
        seg_left--;
        send_tick(make_tick(kind));
      end
    end

    drain_results();
    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/wfmc_pkg.sv
hw/rtl/wfmc_cfg_regs.sv
hw/rtl/wfmc_core.sv
hw/rtl/wall_follow_mode_controller.sv
sim/wfmc_checker.sv
sim/tb_wall_follow_mode_controller.sv
